FILE: rtl/core/mwf_pkg.sv
// ----------------------------------------------------------------------------
// mwf_pkg: shared types and constants of the wall follower step
// Register codes, node kinds, reset values and the turn and classify helpers.
// ----------------------------------------------------------------------------
package mwf_pkg;

   localparam int DIST_BITS_DEFAULT = 12;
   localparam int LIMIT_BITS        = 12;
   localparam int RUN_BITS          = 3;
   localparam int KIND_BITS         = 3;
   localparam int CSR_IDX_BITS      = 2;
   localparam int CSR_DATA_BITS     = 12;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WALL_LIMIT      = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NEAR_LIMIT      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEAK_RUN_NEEDED = 2'd2;

   localparam logic [LIMIT_BITS-1:0] WALL_LIMIT_RESET      = 12'd570;
   localparam logic [LIMIT_BITS-1:0] NEAR_LIMIT_RESET      = 12'd280;
   localparam logic [RUN_BITS-1:0]   LEAK_RUN_NEEDED_RESET = 3'd2;

   localparam logic [KIND_BITS-1:0] KIND_CORRIDOR = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_TURN     = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_DEAD_END = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_T        = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_Z        = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_START    = 3'd5;

   localparam logic [1:0] HEADING_NORTH = 2'd0;
   localparam logic [1:0] HEADING_EAST  = 2'd1;
   localparam logic [1:0] HEADING_SOUTH = 2'd2;
   localparam logic [1:0] HEADING_WEST  = 2'd3;

   typedef struct packed {
      logic [LIMIT_BITS-1:0] wall_limit;
      logic [LIMIT_BITS-1:0] near_limit;
      logic [RUN_BITS-1:0]   leak_run_needed;
   } cfg_type;

   typedef struct packed {
      logic [1:0]           heading;
      logic [3:0]           openings;
      logic                 pending;
      logic [RUN_BITS-1:0]  leak_run;
      logic [KIND_BITS-1:0] kind;
   } state_type;

   typedef struct packed {
      logic [1:0]           heading;
      logic                 new_node;
      logic [KIND_BITS-1:0] node_kind;
      logic [3:0]           open_sides;
      logic                 leak_confirmed;
   } result_type;

   function automatic logic [KIND_BITS-1:0] classify(input logic [3:0] op);
      logic [2:0] cnt;
      cnt = 3'(op[0]) + 3'(op[1]) + 3'(op[2]) + 3'(op[3]);
      case (cnt)
         3'd3:    classify = KIND_T;
         3'd2:    classify = (op[0] == op[2]) ? KIND_CORRIDOR : KIND_TURN;
         3'd1:    classify = KIND_DEAD_END;
         default: classify = KIND_Z;
      endcase
   endfunction

   function automatic logic [1:0] right_hand(input logic [1:0] h, input logic [3:0] op);
      logic [1:0] right;
      logic [1:0] left;
      right = h + 2'd1;
      left  = h + 2'd3;
      if (op[right]) begin
         right_hand = right;
      end else if (op[h]) begin
         right_hand = h;
      end else if (op[left]) begin
         right_hand = left;
      end else begin
         right_hand = h + 2'd2;
      end
   endfunction

endpackage

FILE: rtl/core/mwf_step_logic.sv
// ----------------------------------------------------------------------------
// mwf_step_logic: decision logic for one sensor sample
// Openings, front pick, node detection, classification, turn and leak run.
// ----------------------------------------------------------------------------
module mwf_step_logic
   import mwf_pkg::*;
#(
   parameter int DIST_BITS = DIST_BITS_DEFAULT
) (
   input  logic [3:0][DIST_BITS-1:0] sensor_dist,
   input  logic                      leak_seen,
   input  cfg_type                   cfg,
   input  state_type                 state,
   output state_type                 state_next,
   output result_type                result,
   output logic [DIST_BITS-1:0]      front_distance
);

   localparam int CMP_BITS = (DIST_BITS > LIMIT_BITS) ? DIST_BITS : LIMIT_BITS;

   logic [CMP_BITS-1:0]  wall_cmp;
   logic [CMP_BITS-1:0]  near_cmp;
   logic [CMP_BITS-1:0]  front_cmp;
   logic [3:0]           op;
   logic                 changed;
   logic                 fresh;
   logic                 confirmed;
   logic [KIND_BITS-1:0] kind;

   assign wall_cmp = CMP_BITS'(cfg.wall_limit);
   assign near_cmp = CMP_BITS'(cfg.near_limit);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         op[i] = CMP_BITS'(sensor_dist[i]) > wall_cmp;
      end
   end

   always_comb begin
      case (state.heading)
         HEADING_NORTH: front_distance = sensor_dist[0];
         HEADING_EAST:  front_distance = sensor_dist[1];
         HEADING_SOUTH: front_distance = sensor_dist[2];
         default:       front_distance = sensor_dist[3];
      endcase
   end

   assign front_cmp = CMP_BITS'(front_distance);
   assign changed   = op != state.openings;
   assign fresh     = changed && ((state.pending && front_cmp > wall_cmp) ||
                                  front_cmp < near_cmp);
   assign kind      = classify(op);
   assign confirmed = leak_seen && (state.leak_run >= cfg.leak_run_needed);

   always_comb begin
      state_next         = state;
      state_next.pending = changed;
      if (!leak_seen) begin
         state_next.leak_run = '0;
      end else if (!confirmed) begin
         state_next.leak_run = state.leak_run + RUN_BITS'(1);
      end
      if (fresh) begin
         state_next.openings = op;
         state_next.kind     = kind;
         if (kind != KIND_CORRIDOR) begin
            state_next.heading = right_hand(state.heading, op);
         end
      end
   end

   always_comb begin
      result.heading        = state_next.heading;
      result.new_node       = fresh;
      result.node_kind      = state_next.kind;
      result.open_sides     = op;
      result.leak_confirmed = confirmed;
   end

endmodule

FILE: rtl/core/maze_wall_follower_step.sv
// ----------------------------------------------------------------------------
// maze_wall_follower_step: right-hand wall follower, one step per sample
// Input register, decision logic with walker state, result register.
//
// channel  | dir | handshake              | payload
// req      | in  | req_tvalid/req_tready  | four distances, leak_seen
// rsp      | out | rsp_tvalid/rsp_tready  | heading, node flags, openings, front
// csr      | in  | csr_we                 | csr_index, csr_wdata
//
// One request per cycle while no result stalls; a request passes the input register, then the result register.
// Walker state updates in the single cycle a request moves to the result register.
// Reset clears state to north, all closed, kind start, and loads register defaults.
// A stalled result holds the input register; a request is taken while the
// result waits as long as the input register is free.
// ----------------------------------------------------------------------------
module maze_wall_follower_step
   import mwf_pkg::*;
#(
   parameter  int DIST_BITS = DIST_BITS_DEFAULT,
   localparam int REQ_USED  = 4 * DIST_BITS + 1,
   localparam int REQ_BITS  = ((REQ_USED + 7) / 8) * 8,
   localparam int RSP_USED  = $bits(result_type) + DIST_BITS,
   localparam int RSP_BITS  = ((RSP_USED + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // dist_north, dist_east, dist_south, dist_west, leak_seen, zero fill
   input  logic [REQ_BITS-1:0]      req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // heading, new_node, node_kind, open_sides, front_distance, leak_confirmed, zero fill
   output logic [RSP_BITS-1:0]      rsp_tdata,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type                  cfg_ff, cfg_in;
   state_type                state_ff, state_in;
   logic                     s1_valid_ff, s1_valid_in;
   logic [3:0][DIST_BITS-1:0] s1_dist_ff, s1_dist_in;
   logic                     s1_leak_ff, s1_leak_in;
   logic                     out_valid_ff, out_valid_in;
   result_type               out_res_ff, out_res_in;
   logic [DIST_BITS-1:0]     out_front_ff, out_front_in;

   state_type                step_state;
   result_type               step_res;
   logic [DIST_BITS-1:0]     step_front;
   logic                     stall;
   logic                     advance;
   logic                     take;

   mwf_step_logic #(
      .DIST_BITS(DIST_BITS)
   ) u_logic (
      .sensor_dist    (s1_dist_ff),
      .leak_seen      (s1_leak_ff),
      .cfg            (cfg_ff),
      .state          (state_ff),
      .state_next     (step_state),
      .result         (step_res),
      .front_distance (step_front)
   );

   assign stall      = out_valid_ff && !rsp_tready;
   assign advance    = s1_valid_ff && !stall;
   assign req_tready = !s1_valid_ff || !stall;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WALL_LIMIT:      cfg_in.wall_limit      = csr_wdata[LIMIT_BITS-1:0];
            CSR_NEAR_LIMIT:      cfg_in.near_limit      = csr_wdata[LIMIT_BITS-1:0];
            CSR_LEAK_RUN_NEEDED: cfg_in.leak_run_needed = csr_wdata[RUN_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_dist_in  = s1_dist_ff;
      s1_leak_in  = s1_leak_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (take) begin
         s1_valid_in = 1'b1;
         for (int i = 0; i < 4; i++) begin
            s1_dist_in[i] = req_tdata[i*DIST_BITS +: DIST_BITS];
         end
         s1_leak_in = req_tdata[4*DIST_BITS];
      end
   end

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_res_in   = out_res_ff;
      out_front_in = out_front_ff;
      if (advance) begin
         state_in     = step_state;
         out_valid_in = 1'b1;
         out_res_in   = step_res;
         out_front_in = step_front;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wall_limit      <= WALL_LIMIT_RESET;
         cfg_ff.near_limit      <= NEAR_LIMIT_RESET;
         cfg_ff.leak_run_needed <= LEAK_RUN_NEEDED_RESET;
         state_ff.heading       <= HEADING_NORTH;
         state_ff.openings      <= '0;
         state_ff.pending       <= 1'b0;
         state_ff.leak_run      <= '0;
         state_ff.kind          <= KIND_START;
         s1_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_dist_ff   <= s1_dist_in;
      s1_leak_ff   <= s1_leak_in;
      out_res_ff   <= out_res_in;
      out_front_ff <= out_front_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_BITS'({out_res_ff.leak_confirmed, out_front_ff,
                                  out_res_ff.open_sides, out_res_ff.node_kind,
                                  out_res_ff.new_node, out_res_ff.heading});

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && out_valid_ff && !rsp_tready)
      else $error("request refused without a stalled result");

   a_heading_holds: assert property (@(posedge clock) disable iff (reset)
      advance && !step_res.new_node |=> state_ff.heading == $past(state_ff.heading))
      else $error("heading changed without a new node");

   a_openings_stored: assert property (@(posedge clock) disable iff (reset)
      advance && step_res.new_node |=> state_ff.openings == out_res_ff.open_sides)
      else $error("new node did not store its openings");

   a_leak_run_holds: assert property (@(posedge clock) disable iff (reset)
      advance && step_res.leak_confirmed |=> state_ff.leak_run == $past(state_ff.leak_run))
      else $error("leak run moved while confirmed");

   a_state_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> state_ff == $past(state_ff))
      else $error("walker state changed without a request");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the wall follower step
// Streams distance samples into the block, predicts each step's heading,
// node flags, openings, front distance and leak state, and checks every
// result in order under several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb;
   import mwf_pkg::*;

   localparam int DIST_W = 12;
   localparam int REQ_W  = 56;
   localparam int RSP_W  = 24;

   typedef struct packed {
      logic                   leak_seen;
      logic [3:0][DIST_W-1:0] sensor_dist;
   } sample_type;

   typedef struct packed {
      logic                 leak_confirmed;
      logic [DIST_W-1:0]    front_distance;
      logic [3:0]           open_sides;
      logic [KIND_BITS-1:0] node_kind;
      logic                 new_node;
      logic [1:0]           heading;
   } step_result_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_W-1:0]         req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_W-1:0]         rsp_tdata;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   maze_wall_follower_step DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sample_type      pending_samples[$];
   step_result_type expected_steps[$];
   int              idle_pct    = 0;
   int              stall_pct   = 0;
   logic            hold_sender = 1'b0;
   logic            req_taken   = 1'b0;
   int              error_count = 0;

   cfg_type              walk_cfg;
   logic [1:0]           walk_heading;
   logic [3:0]           walk_openings;
   logic                 walk_pending;
   logic [RUN_BITS-1:0]  walk_leak_run;
   logic [KIND_BITS-1:0] walk_kind;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic predict_walk(input sample_type s);
      step_result_type r;
      logic [3:0]      seen_open;
      logic [11:0]     front;
      logic [1:0]      next_dir;
      logic [1:0]      try_dir;
      logic            fresh;
      logic            confirmed;
      int              cnt;
      seen_open = '0;
      for (int i = 0; i < 4; i++) begin
         if (s.sensor_dist[i] > walk_cfg.wall_limit) seen_open[i] = 1'b1;
      end
      front     = s.sensor_dist[walk_heading];
      confirmed = 1'b0;
      fresh     = 1'b0;

      if (s.leak_seen) begin
         if (walk_leak_run >= walk_cfg.leak_run_needed) confirmed = 1'b1;
         else walk_leak_run = walk_leak_run + RUN_BITS'(1);
      end else begin
         walk_leak_run = '0;
      end

      if (seen_open == walk_openings) begin
         walk_pending = 1'b0;
      end else begin
         if ((walk_pending && front > walk_cfg.wall_limit) || front < walk_cfg.near_limit)
            fresh = 1'b1;
         walk_pending = 1'b1;
      end

      if (fresh) begin
         cnt = int'(seen_open[0]) + int'(seen_open[1]) + int'(seen_open[2])
             + int'(seen_open[3]);
         case (cnt)
            1: walk_kind = KIND_DEAD_END;
            2: walk_kind = (seen_open[0] == seen_open[2]) ? KIND_CORRIDOR : KIND_TURN;
            3: walk_kind = KIND_T;
            default: walk_kind = KIND_Z;
         endcase
         walk_openings = seen_open;
         if (walk_kind != KIND_CORRIDOR) begin
            next_dir = walk_heading + 2'd2;
            for (int k = 2; k >= 0; k--) begin
               case (k)
                  0: try_dir = walk_heading + 2'd1;
                  1: try_dir = walk_heading;
                  default: try_dir = walk_heading + 2'd3;
               endcase
               if (seen_open[try_dir]) next_dir = try_dir;
            end
            walk_heading = next_dir;
         end
      end

      r.heading        = walk_heading;
      r.new_node       = fresh;
      r.node_kind      = walk_kind;
      r.open_sides     = seen_open;
      r.front_distance = front;
      r.leak_confirmed = confirmed;
      expected_steps.push_back(r);
   endtask

   task automatic check_step(input step_result_type got);
      step_result_type want;
      if (expected_steps.size() == 0) begin
         error_count++;
         if (error_count <= 10) $display("unexpected result %h", got);
      end else begin
         want = expected_steps.pop_front();
         if (got.heading != want.heading || got.new_node != want.new_node
             || got.node_kind != want.node_kind || got.open_sides != want.open_sides
             || got.front_distance != want.front_distance
             || got.leak_confirmed != want.leak_confirmed) begin
            error_count++;
            if (error_count <= 10)
               $display({"mismatch: heading %0d/%0d node %0d/%0d kind %0d/%0d ",
                         "open %h/%h front %0d/%0d leak %0d/%0d (exp/got)"},
                        want.heading, got.heading, want.new_node, got.new_node,
                        want.node_kind, got.node_kind, want.open_sides, got.open_sides,
                        want.front_distance, got.front_distance,
                        want.leak_confirmed, got.leak_confirmed);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         walk_cfg.wall_limit      = WALL_LIMIT_RESET;
         walk_cfg.near_limit      = NEAR_LIMIT_RESET;
         walk_cfg.leak_run_needed = LEAK_RUN_NEEDED_RESET;
         walk_heading  = HEADING_NORTH;
         walk_openings = '0;
         walk_pending  = 1'b0;
         walk_leak_run = '0;
         walk_kind     = KIND_START;
         expected_steps.delete();
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (csr_we) begin
            case (csr_index)
               CSR_WALL_LIMIT:      walk_cfg.wall_limit      = csr_wdata;
               CSR_NEAR_LIMIT:      walk_cfg.near_limit      = csr_wdata;
               CSR_LEAK_RUN_NEEDED: walk_cfg.leak_run_needed = csr_wdata[RUN_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_walk(sample_type'(req_tdata[48:0]));
         if (rsp_tvalid && rsp_tready) check_step(step_result_type'(rsp_tdata[22:0]));
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= stall_pct);
         if (!req_tvalid || req_taken) begin
            if (!hold_sender && pending_samples.size() > 0
                && $urandom_range(99, 0) >= idle_pct) begin
               req_tdata  <= REQ_W'(pending_samples.pop_front());
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // hold until every accepted request has its result, then let the pipe settle
   task automatic quiesce();
      int waited;
      waited = 0;
      while (!(expected_steps.size() == 0 && !req_tvalid
               && (hold_sender || pending_samples.size() == 0)) && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic setup_phase(input int wall, input int near_l, input int leak_need,
                              input int idle, input int stall);
      quiesce();
      idle_pct  = idle;
      stall_pct = stall;
      write_reg(CSR_WALL_LIMIT, wall);
      write_reg(CSR_NEAR_LIMIT, near_l);
      write_reg(CSR_LEAK_RUN_NEEDED, leak_need);
   endtask

   task automatic add_sample(input int n, input int e, input int s, input int w,
                             input logic leak);
      sample_type x;
      x.sensor_dist[0] = DIST_W'(n);
      x.sensor_dist[1] = DIST_W'(e);
      x.sensor_dist[2] = DIST_W'(s);
      x.sensor_dist[3] = DIST_W'(w);
      x.leak_seen      = leak;
      pending_samples.push_back(x);
   endtask

   function automatic sample_type shaped_sample(input logic [3:0] pattern, input logic leak,
                                                input int wall, input int near_l);
      sample_type x;
      int         low_top;
      for (int i = 0; i < 4; i++) begin
         if (pattern[i]) begin
            x.sensor_dist[i] = (wall >= 4095) ? 12'd4095
                                              : DIST_W'($urandom_range(4095, wall + 1));
         end else begin
            low_top = (near_l > 0 && near_l <= wall && $urandom_range(2, 0) == 0)
                      ? near_l - 1 : wall;
            x.sensor_dist[i] = DIST_W'($urandom_range(low_top, 0));
         end
      end
      x.leak_seen = leak;
      return x;
   endfunction

   // runs of a fixed opening pattern so nodes get confirmed, with some raw noise
   task automatic add_random(input int count, input int wall, input int near_l);
      sample_type x;
      logic [3:0] pattern;
      logic       leak;
      int         run_len;
      int         made;
      made = 0;
      while (made < count) begin
         if ($urandom_range(99, 0) < 15) begin
            x.sensor_dist[0] = DIST_W'($urandom);
            x.sensor_dist[1] = DIST_W'($urandom);
            x.sensor_dist[2] = DIST_W'($urandom);
            x.sensor_dist[3] = DIST_W'($urandom);
            x.leak_seen      = 1'($urandom_range(1, 0));
            pending_samples.push_back(x);
            made++;
         end else begin
            pattern = 4'($urandom);
            leak    = 1'($urandom_range(1, 0));
            run_len = $urandom_range(6, 1);
            for (int k = 0; k < run_len && made < count; k++) begin
               if ($urandom_range(9, 0) == 0) leak = ~leak;
               pending_samples.push_back(shaped_sample(pattern, leak, wall, near_l));
               made++;
            end
         end
      end
   endtask

   initial begin
      int wall;
      int near_l;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset limits, extremes, boundaries and leak runs
      add_sample(0, 0, 0, 0, 1'b1);
      add_sample(4095, 4095, 4095, 4095, 1'b1);
      add_sample(4095, 4095, 4095, 4095, 1'b1);
      add_sample(4095, 0, 4095, 0, 1'b0);
      add_sample(0, 0, 0, 0, 1'b0);
      add_sample(0, 0, 0, 4095, 1'b1);
      add_sample(570, 571, 570, 570, 1'b1);
      add_sample(571, 571, 570, 570, 1'b1);
      add_sample(571, 571, 571, 570, 1'b1);
      add_sample(280, 571, 280, 280, 1'b1);
      add_sample(279, 279, 279, 279, 1'b1);
      add_sample(4095, 571, 0, 4095, 1'b0);
      add_sample(0, 4095, 4095, 0, 1'b1);
      add_sample(4095, 0, 4095, 4095, 1'b1);
      add_sample(0, 4095, 0, 4095, 1'b0);
      add_sample(0, 4095, 0, 4095, 1'b0);
      add_sample(4095, 4095, 0, 0, 1'b1);
      add_sample(0, 0, 4095, 4095, 1'b1);
      add_sample(4095, 0, 0, 0, 1'b0);
      add_sample(0, 0, 0, 0, 1'b1);
      add_sample(2730, 1365, 2730, 1365, 1'b1);
      add_sample(1365, 2730, 1365, 2730, 1'b0);

      setup_phase(0, 4095, 0, 0, 0);
      add_random(120, 0, 4095);

      setup_phase(4095, 0, 7, 77, 0);
      add_random(100, 4095, 0);

      setup_phase(570, 280, 2, 0, 77);
      add_random(150, 570, 280);

      wall   = $urandom_range(1500, 200);
      near_l = $urandom_range(wall, 0);
      setup_phase(wall, near_l, $urandom_range(7, 0), 35, 35);
      add_random(150, wall, near_l);
      while (pending_samples.size() > 75) @(posedge clock);
      hold_sender = 1'b1;
      quiesce();
      hold_sender = 1'b0;

      wall   = $urandom_range(4095, 0);
      near_l = $urandom_range(4095, 0);
      setup_phase(wall, near_l, $urandom_range(7, 0), $urandom_range(50, 0),
                  $urandom_range(50, 0));
      add_random(130, wall, near_l);

      quiesce();
      repeat (10) @(posedge clock);
      error_count += expected_steps.size() + pending_samples.size();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
